[hw/rtl/face_vertex_dedup_table_macros.svh]
`ifndef FACE_VERTEX_DEDUP_TABLE_MACROS_SVH
`define FACE_VERTEX_DEDUP_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FVD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fvd assertion failed");

// Next-cycle implication.
`define FVD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fvd assertion failed");

`endif

[hw/rtl/fvd_pkg.sv]
package fvd_pkg;

  // Fixed field widths of the request and result ports
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned FIELD_W   = 21;
  localparam int unsigned IDX_OUT_W = 20;
  localparam int unsigned VIDX_W    = 12;
  localparam int unsigned STATUS_W  = 2;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_POS    = 3'd0,
    MODE_TEX    = 3'd1,
    MODE_NRM    = 3'd2,
    MODE_CORNER = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Kind of result the controller asks the datapath to emit
  typedef enum logic [1:0] {
    RES_RANGE = 2'd0,
    RES_HIT   = 2'd1,
    RES_NEW   = 2'd2,
    RES_FULL  = 2'd3
  } res_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_item;
    logic bump_pos;
    logic bump_tex;
    logic bump_nrm;
    logic clear_counts;
    logic load_hash;
    logic ram_rd;
    logic probe_next;
    logic insert;
    logic clr_step;
    logic emit;
    res_e kind;
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic range_ok;
    logic slot_valid;
    logic key_match;
    logic table_full;
    logic clr_last;
  } dp_stat_t;

endpackage

[hw/rtl/face_vertex_dedup_table.sv]
// Face corner: HASH checks the range, READ reads the slot RAM, CMP compares, and the
// result strobe is registered from CMP; busy is high until then. An out-of-range
// reference answers from HASH. Each extra probe of a collision chain repeats READ and CMP
// (one slot RAM read plus one compare). Declarations and ignored modes stay idle. Clear
// and reset sweep the slot RAM one slot a cycle, 2^(clog2(TABLE_DEPTH)+1) slots
// (8192 by default), busy high; counts reset to 1, entries to 0. Receiver cannot stall.
module face_vertex_dedup_table #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned REF_WIDTH   = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [fvd_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [fvd_pkg::FIELD_W-1:0]  pos_ref_i,
  input  logic signed [fvd_pkg::FIELD_W-1:0]  tex_ref_i,
  input  logic signed [fvd_pkg::FIELD_W-1:0]  nrm_ref_i,
  output logic                                valid_o,
  output logic [fvd_pkg::VIDX_W-1:0]          vert_id_o,
  output logic                                is_new_o,
  output logic [fvd_pkg::IDX_OUT_W-1:0]       pos_index_o,
  output logic [fvd_pkg::IDX_OUT_W-1:0]       tex_index_o,
  output logic [fvd_pkg::IDX_OUT_W-1:0]       nrm_index_o,
  output logic [fvd_pkg::STATUS_W-1:0]        status_o
);

  fvd_pkg::ctrl_cmd_t cmd;
  fvd_pkg::dp_stat_t  st;

  // Sequencer
  fvd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_i),
    .busy_o  (busy),
    .st_i    (st),
    .cmd_o   (cmd)
  );

  // Counts, hash table and result registers
  fvd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REF_WIDTH   (REF_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pos_ref_i   (pos_ref_i),
    .tex_ref_i   (tex_ref_i),
    .nrm_ref_i   (nrm_ref_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .valid_o     (valid_o),
    .vert_id_o   (vert_id_o),
    .is_new_o    (is_new_o),
    .pos_index_o (pos_index_o),
    .tex_index_o (tex_index_o),
    .nrm_index_o (nrm_index_o),
    .status_o    (status_o)
  );

endmodule

[hw/rtl/fvd_ram.sv]
module fvd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fvd_ctrl.sv]
`include "face_vertex_dedup_table_macros.svh"

module fvd_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fvd_pkg::MODE_W-1:0]     mode_i,
  output logic                           busy_o,
  input  fvd_pkg::dp_stat_t              st_i,
  output fvd_pkg::ctrl_cmd_t             cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_READ  = 5'b00100,
    S_CMP   = 5'b01000,
    S_CLEAR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Table sweep runs straight out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (mode_i)
            fvd_pkg::MODE_POS: cmd_o.bump_pos = 1'b1;
            fvd_pkg::MODE_TEX: cmd_o.bump_tex = 1'b1;
            fvd_pkg::MODE_NRM: cmd_o.bump_nrm = 1'b1;
            fvd_pkg::MODE_CORNER: begin
              cmd_o.load_item = 1'b1;
              state_d         = S_HASH;
            end
            fvd_pkg::MODE_CLEAR: begin
              cmd_o.clear_counts = 1'b1;
              state_d            = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (!st_i.range_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = fvd_pkg::RES_RANGE;
          state_d    = S_IDLE;
        end else begin
          cmd_o.load_hash = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        if (st_i.slot_valid && st_i.key_match) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = fvd_pkg::RES_HIT;
          state_d    = S_IDLE;
        end else if (st_i.slot_valid) begin
          // occupied by another key: linear probe
          cmd_o.probe_next = 1'b1;
          state_d          = S_READ;
        end else if (st_i.table_full) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = fvd_pkg::RES_FULL;
          state_d    = S_IDLE;
        end else begin
          cmd_o.insert = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = fvd_pkg::RES_NEW;
          state_d      = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `FVD_ASSERT_NOW(a_emit_state, clk_i, rst_ni, cmd_o.emit, state_q == S_HASH || state_q == S_CMP)
  `FVD_ASSERT_NOW(a_insert_room, clk_i, rst_ni, cmd_o.insert, !st_i.table_full && !st_i.slot_valid)
  `FVD_ASSERT_NEXT(a_corner_hash, clk_i, rst_ni, state_q == S_IDLE && start_i && mode_i == fvd_pkg::MODE_CORNER, state_q == S_HASH)
  `FVD_ASSERT_NEXT(a_clear_sweep, clk_i, rst_ni, state_q == S_CLEAR && !st_i.clr_last, state_q == S_CLEAR)

endmodule

[hw/rtl/fvd_datapath.sv]
`include "face_vertex_dedup_table_macros.svh"

module fvd_datapath #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned REF_WIDTH   = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [fvd_pkg::FIELD_W-1:0]  pos_ref_i,
  input  logic signed [fvd_pkg::FIELD_W-1:0]  tex_ref_i,
  input  logic signed [fvd_pkg::FIELD_W-1:0]  nrm_ref_i,
  input  fvd_pkg::ctrl_cmd_t                  cmd_i,
  output fvd_pkg::dp_stat_t                   st_o,
  output logic                                valid_o,
  output logic [fvd_pkg::VIDX_W-1:0]          vert_id_o,
  output logic                                is_new_o,
  output logic [fvd_pkg::IDX_OUT_W-1:0]       pos_index_o,
  output logic [fvd_pkg::IDX_OUT_W-1:0]       tex_index_o,
  output logic [fvd_pkg::IDX_OUT_W-1:0]       nrm_index_o,
  output logic [fvd_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned FieldW    = fvd_pkg::FIELD_W;
  localparam int unsigned ExtW      = FieldW + 2;
  localparam int unsigned IdxOutW   = fvd_pkg::IDX_OUT_W;
  localparam int unsigned VidxW     = fvd_pkg::VIDX_W;
  localparam int unsigned CntW      = REF_WIDTH + 1;
  localparam int unsigned IdxW      = $clog2(TABLE_DEPTH);
  localparam int unsigned EntW      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HashW     = IdxW + 1;
  localparam int unsigned HashDepth = 2 ** HashW;
  localparam int unsigned KeyW      = 3 * REF_WIDTH;
  localparam int unsigned SlotW     = 1 + KeyW + IdxW;
  localparam int unsigned NChunk    = (KeyW + HashW - 1) / HashW;
  localparam int unsigned KextW     = NChunk * HashW;

  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntMax = {1'b1, {REF_WIDTH{1'b0}}};
  localparam logic [EntW-1:0] EntMax = EntW'(TABLE_DEPTH);

  // Resolve one reference: {in_range, index}
  function automatic logic [REF_WIDTH:0] resolve(input logic [FieldW-1:0] raw,
                                                 input logic [CntW-1:0]   cnt);
    logic [ExtW-1:0] ext_raw;
    logic [ExtW-1:0] ext_cnt;
    logic [ExtW-1:0] v;
    logic            ok;
    ext_raw = {{2{raw[FieldW-1]}}, raw};
    ext_cnt = ExtW'(cnt);
    v       = raw[FieldW-1] ? ext_raw + ext_cnt : ext_raw;
    ok      = !v[ExtW-1] && (v < ext_cnt);
    return {ok, v[REF_WIDTH-1:0]};
  endfunction

  logic [CntW-1:0]      pos_cnt_q, tex_cnt_q, nrm_cnt_q;
  logic [EntW-1:0]      entry_cnt_q;
  logic [HashW-1:0]     clr_q;
  logic                 valid_q;
  logic [REF_WIDTH-1:0] p_q, t_q, n_q;
  logic                 ok_q;
  logic [HashW-1:0]     probe_q;
  logic [VidxW-1:0]     vi_q;
  logic                 is_new_q;
  logic [IdxOutW-1:0]   pi_q, ti_q, ni_q;
  logic [fvd_pkg::STATUS_W-1:0] status_q;

  logic [REF_WIDTH:0]   pos_res, tex_res, nrm_res;
  logic [KeyW-1:0]      key;
  logic [KextW-1:0]     key_ext;
  logic [HashW-1:0]     hash;
  logic                 ram_we;
  logic [HashW-1:0]     ram_waddr;
  logic [SlotW-1:0]     ram_wdata;
  logic [SlotW-1:0]     ram_rdata;
  logic                 slot_valid;
  logic [KeyW-1:0]      slot_key;
  logic [IdxW-1:0]      slot_idx;
  logic                 table_full;

  // Reference resolution against the running counts
  always_comb begin
    pos_res = resolve(pos_ref_i, pos_cnt_q);
    tex_res = resolve(tex_ref_i, tex_cnt_q);
    nrm_res = resolve(nrm_ref_i, nrm_cnt_q);
  end

  // XOR fold of the key down to a slot address
  assign key     = {p_q, t_q, n_q};
  assign key_ext = KextW'(key);
  always_comb begin
    hash = '0;
    for (int c = 0; c < NChunk; c++) begin
      hash = hash ^ key_ext[c*HashW +: HashW];
    end
  end

  // Slot decode
  assign slot_valid = ram_rdata[SlotW-1];
  assign slot_key   = ram_rdata[SlotW-2 -: KeyW];
  assign slot_idx   = ram_rdata[IdxW-1:0];
  assign table_full = (entry_cnt_q == EntMax);

  assign st_o.range_ok   = ok_q;
  assign st_o.slot_valid = slot_valid;
  assign st_o.key_match  = (slot_key == key);
  assign st_o.table_full = table_full;
  assign st_o.clr_last   = &clr_q;

  // Slot memory write: sweep writes empty slots, insert writes a new key
  assign ram_we    = cmd_i.clr_step | cmd_i.insert;
  assign ram_waddr = cmd_i.clr_step ? clr_q : probe_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : {1'b1, key, entry_cnt_q[IdxW-1:0]};

  fvd_ram #(
    .WIDTH (SlotW),
    .DEPTH (HashDepth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (probe_q),
    .rdata_o (ram_rdata)
  );

  // Counts, entry count, sweep pointer, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_cnt_q   <= CntOne;
      tex_cnt_q   <= CntOne;
      nrm_cnt_q   <= CntOne;
      entry_cnt_q <= '0;
      clr_q       <= '0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.clear_counts) begin
        pos_cnt_q   <= CntOne;
        tex_cnt_q   <= CntOne;
        nrm_cnt_q   <= CntOne;
        entry_cnt_q <= '0;
      end
      if (cmd_i.bump_pos && pos_cnt_q != CntMax) begin
        pos_cnt_q <= pos_cnt_q + 1'b1;
      end
      if (cmd_i.bump_tex && tex_cnt_q != CntMax) begin
        tex_cnt_q <= tex_cnt_q + 1'b1;
      end
      if (cmd_i.bump_nrm && nrm_cnt_q != CntMax) begin
        nrm_cnt_q <= nrm_cnt_q + 1'b1;
      end
      if (cmd_i.insert) begin
        entry_cnt_q <= entry_cnt_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Corner key, probe pointer and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      p_q  <= pos_res[REF_WIDTH-1:0];
      t_q  <= tex_res[REF_WIDTH-1:0];
      n_q  <= nrm_res[REF_WIDTH-1:0];
      ok_q <= pos_res[REF_WIDTH] & tex_res[REF_WIDTH] & nrm_res[REF_WIDTH];
    end
    if (cmd_i.load_hash) begin
      probe_q <= hash;
    end else if (cmd_i.probe_next) begin
      probe_q <= probe_q + 1'b1;
    end
    if (cmd_i.emit) begin
      pi_q <= IdxOutW'(p_q);
      ti_q <= IdxOutW'(t_q);
      ni_q <= IdxOutW'(n_q);
      case (cmd_i.kind)
        fvd_pkg::RES_HIT: begin
          vi_q     <= VidxW'(slot_idx);
          is_new_q <= 1'b0;
          status_q <= fvd_pkg::ST_OK;
        end
        fvd_pkg::RES_NEW: begin
          vi_q     <= VidxW'(entry_cnt_q[IdxW-1:0]);
          is_new_q <= 1'b1;
          status_q <= fvd_pkg::ST_OK;
        end
        fvd_pkg::RES_FULL: begin
          vi_q     <= '0;
          is_new_q <= 1'b0;
          status_q <= fvd_pkg::ST_FULL;
        end
        default: begin
          // out of range: all fields but status zero
          vi_q     <= '0;
          is_new_q <= 1'b0;
          pi_q     <= '0;
          ti_q     <= '0;
          ni_q     <= '0;
          status_q <= fvd_pkg::ST_RANGE;
        end
      endcase
    end
  end

  assign valid_o     = valid_q;
  assign vert_id_o   = vi_q;
  assign is_new_o    = is_new_q;
  assign pos_index_o = pi_q;
  assign tex_index_o = ti_q;
  assign nrm_index_o = ni_q;
  assign status_o    = status_q;

  `FVD_ASSERT_NOW(a_range_zero, clk_i, rst_ni, valid_q && status_q == fvd_pkg::ST_RANGE, vi_q == '0 && !is_new_q)
  `FVD_ASSERT_NEXT(a_entry_grow, clk_i, rst_ni, cmd_i.insert, entry_cnt_q == $past(entry_cnt_q) + 1'b1)

endmodule

[tb/sv/face_vertex_dedup_table_tb.sv]
`timescale 1ns / 1ps

module face_vertex_dedup_table_tb;

  localparam int unsigned TABLE_DEPTH  = 4096;
  localparam int unsigned REF_WIDTH    = 20;
  localparam int unsigned COUNT_CAP    = 1 << REF_WIDTH;
  localparam int          REF_MAX      = (1 << (fvd_pkg::FIELD_W - 1)) - 1;
  localparam int          REF_MIN      = -(1 << (fvd_pkg::FIELD_W - 1));
  // Eight indices per attribute: 512 distinct triples crowded into long probe chains
  localparam int unsigned FILL_SPAN    = 8;
  localparam int unsigned RANDOM_ITEMS = 1080;
  localparam int unsigned SETTLE       = 64;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  // Mode codes the block ignores
  localparam logic [fvd_pkg::MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [fvd_pkg::MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [fvd_pkg::VIDX_W-1:0]    vidx;
    logic                          is_new;
    logic [fvd_pkg::IDX_OUT_W-1:0] pos;
    logic [fvd_pkg::IDX_OUT_W-1:0] tex;
    logic [fvd_pkg::IDX_OUT_W-1:0] nrm;
    fvd_pkg::status_e              st;
  } corner_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic [fvd_pkg::MODE_W-1:0]          mode_i;
  logic signed [fvd_pkg::FIELD_W-1:0]  pos_ref_i;
  logic signed [fvd_pkg::FIELD_W-1:0]  tex_ref_i;
  logic signed [fvd_pkg::FIELD_W-1:0]  nrm_ref_i;
  logic                                valid_o;
  logic [fvd_pkg::VIDX_W-1:0]          vert_id_o;
  logic                                is_new_o;
  logic [fvd_pkg::IDX_OUT_W-1:0]       pos_index_o;
  logic [fvd_pkg::IDX_OUT_W-1:0]       tex_index_o;
  logic [fvd_pkg::IDX_OUT_W-1:0]       nrm_index_o;
  logic [fvd_pkg::STATUS_W-1:0]        status_o;

  // Shadow state of the dedup table
  int unsigned                pos_count;
  int unsigned                tex_count;
  int unsigned                nrm_count;
  int unsigned                stored_total;
  bit [3*fvd_pkg::FIELD_W-1:0] triple_keys [TABLE_DEPTH];
  corner_result_t             expected_corners [$];

  int unsigned                mismatches = 0;
  int unsigned                cycle_count = 0;

  face_vertex_dedup_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REF_WIDTH   (REF_WIDTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .pos_ref_i   (pos_ref_i),
    .tex_ref_i   (tex_ref_i),
    .nrm_ref_i   (nrm_ref_i),
    .valid_o     (valid_o),
    .vert_id_o   (vert_id_o),
    .is_new_o    (is_new_o),
    .pos_index_o (pos_index_o),
    .tex_index_o (tex_index_o),
    .nrm_index_o (nrm_index_o),
    .status_o    (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_corners.size());
      $display("face_vertex_dedup_table verification failed");
      $finish;
    end
  end

  // Resolves one reference against its count; -1 when out of range
  function automatic int resolve_ref(input logic signed [fvd_pkg::FIELD_W-1:0] raw,
                                     input int unsigned cnt);
    int r;
    r = raw;
    if (r < 0) r += int'(cnt);
    if (r < 0 || r >= int'(cnt)) return -1;
    return r;
  endfunction

  // Advances the shadow table by one accepted request
  task automatic predict_request(input logic [fvd_pkg::MODE_W-1:0] md,
                                 input logic signed [fvd_pkg::FIELD_W-1:0] pr, tr, nr);
    int              p, t, n;
    int              hit_idx;
    bit [3*fvd_pkg::FIELD_W-1:0] key;
    corner_result_t  res;
    case (md)
      fvd_pkg::MODE_POS: if (pos_count < COUNT_CAP) pos_count++;
      fvd_pkg::MODE_TEX: if (tex_count < COUNT_CAP) tex_count++;
      fvd_pkg::MODE_NRM: if (nrm_count < COUNT_CAP) nrm_count++;
      fvd_pkg::MODE_CLEAR: begin
        pos_count    = 1;
        tex_count    = 1;
        nrm_count    = 1;
        stored_total = 0;
      end
      fvd_pkg::MODE_CORNER: begin
        p = resolve_ref(pr, pos_count);
        t = resolve_ref(tr, tex_count);
        n = resolve_ref(nr, nrm_count);
        res = '0;
        if (p < 0 || t < 0 || n < 0) begin
          res.st = fvd_pkg::ST_RANGE;
        end else begin
          res.pos = p[fvd_pkg::IDX_OUT_W-1:0];
          res.tex = t[fvd_pkg::IDX_OUT_W-1:0];
          res.nrm = n[fvd_pkg::IDX_OUT_W-1:0];
          key = {p[fvd_pkg::FIELD_W-1:0], t[fvd_pkg::FIELD_W-1:0], n[fvd_pkg::FIELD_W-1:0]};
          hit_idx = -1;
          for (int i = 0; i < int'(stored_total); i++) begin
            if (triple_keys[i] == key) begin
              hit_idx = i;
              break;
            end
          end
          if (hit_idx >= 0) begin
            res.vidx = hit_idx[fvd_pkg::VIDX_W-1:0];
            res.st   = fvd_pkg::ST_OK;
          end else if (stored_total >= TABLE_DEPTH) begin
            res.st = fvd_pkg::ST_FULL;
          end else begin
            triple_keys[stored_total] = key;
            res.vidx   = stored_total[fvd_pkg::VIDX_W-1:0];
            res.is_new = 1'b1;
            res.st     = fvd_pkg::ST_OK;
            stored_total++;
          end
        end
        expected_corners.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Drives one request and holds it until the block takes it
  task automatic send_request(input logic [fvd_pkg::MODE_W-1:0] md, input int pr, tr, nr);
    @(negedge clk_i);
    start     <= 1'b1;
    mode_i    <= md;
    pos_ref_i <= pr[fvd_pkg::FIELD_W-1:0];
    tex_ref_i <= tr[fvd_pkg::FIELD_W-1:0];
    nrm_ref_i <= nr[fvd_pkg::FIELD_W-1:0];
    do @(posedge clk_i); while (busy);
    predict_request(md, pr[fvd_pkg::FIELD_W-1:0], tr[fvd_pkg::FIELD_W-1:0],
                    nr[fvd_pkg::FIELD_W-1:0]);
  endtask

  // Sender gap of the given number of cycles
  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending until every pending corner has answered
  task automatic wait_results_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk_i);
  endtask

  // Absolute index, or the same index written relative to the end
  function automatic int ref_form(input int idx, input int unsigned cnt);
    if ($urandom_range(1, 0)) return idx - int'(cnt);
    return idx;
  endfunction

  // Valid reference, biased toward low indices so triples repeat
  function automatic int pick_ref(input int unsigned cnt);
    int idx;
    if ($urandom_range(1, 0))
      idx = $urandom_range((cnt > 8) ? 7 : cnt - 1, 0);
    else
      idx = $urandom_range(cnt - 1, 0);
    return ref_form(idx, cnt);
  endfunction

  // Any bit pattern, a reference just outside the valid window, or a valid reference
  function automatic int noise_ref(input int unsigned cnt);
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return int'(cnt);
      2: return -int'(cnt) - 1;
      default: return pick_ref(cnt);
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want_v, got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin : result_check
    corner_result_t want;
    if (rst_ni && valid_o) begin
      if (expected_corners.size() == 0) begin
        $display("%0t: unexpected result, vert_id %0d status %0d",
                 $time, vert_id_o, status_o);
        mismatches++;
      end else begin
        want = expected_corners.pop_front();
        check_field("vert_id", want.vidx, vert_id_o);
        check_field("is_new", want.is_new, is_new_o);
        check_field("pos_index", want.pos, pos_index_o);
        check_field("tex_index", want.tex, tex_index_o);
        check_field("nrm_index", want.nrm, nrm_index_o);
        check_field("status", want.st, status_o);
      end
    end
  end

  // Dummy element, relative refs, hits, range edges, ignored modes
  task automatic test_resolve_directed();
    send_request(fvd_pkg::MODE_CORNER, 0, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, -1, -1, -1);
    send_request(fvd_pkg::MODE_CORNER, 1, 0, 0);
    repeat (3) send_request(fvd_pkg::MODE_POS, REF_MAX, REF_MIN, REF_MAX);
    repeat (2) send_request(fvd_pkg::MODE_TEX, REF_MIN, REF_MAX, REF_MIN);
    repeat (2) send_request(fvd_pkg::MODE_NRM, 0, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 3, 2, 2);
    send_request(fvd_pkg::MODE_CORNER, -1, -1, -1);
    send_request(fvd_pkg::MODE_CORNER, -4, -3, -3);
    send_request(fvd_pkg::MODE_CORNER, -5, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 4, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 0, 3, 0);
    send_request(fvd_pkg::MODE_CORNER, 0, 0, -4);
    // Field extremes, each one out of range
    send_request(fvd_pkg::MODE_CORNER, REF_MAX, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, REF_MIN, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 0, REF_MAX, 0);
    send_request(fvd_pkg::MODE_CORNER, 0, REF_MIN, 0);
    send_request(fvd_pkg::MODE_CORNER, 0, 0, REF_MAX);
    send_request(fvd_pkg::MODE_CORNER, 0, 0, REF_MIN);
    for (int m = MODE_RSVD_FIRST; m <= MODE_RSVD_LAST; m++)
      send_request(m[fvd_pkg::MODE_W-1:0], $urandom, $urandom, $urandom);
    send_request(fvd_pkg::MODE_CORNER, 1, 2, 0);
    wait_results_drained();
  endtask

  // New mesh restarts counts and vertex numbering
  task automatic test_clear_restart();
    send_request(fvd_pkg::MODE_CLEAR, REF_MAX, REF_MAX, REF_MAX);
    send_request(fvd_pkg::MODE_CORNER, 1, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 3, 2, 2);
    send_request(fvd_pkg::MODE_CORNER, 0, 0, -1);
    send_request(fvd_pkg::MODE_POS, 0, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, -1, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 0, 0, 0);
    wait_results_drained();
  endtask

  // Dense fill with long collision chains, then hits and edges on the crowded table
  task automatic test_dense_fill();
    send_request(fvd_pkg::MODE_CLEAR, 0, 0, 0);
    for (int i = 1; i < FILL_SPAN; i++) begin
      send_request(fvd_pkg::MODE_POS, 0, 0, 0);
      send_request(fvd_pkg::MODE_TEX, 0, 0, 0);
      send_request(fvd_pkg::MODE_NRM, 0, 0, 0);
    end
    for (int p = 0; p < FILL_SPAN; p++)
      for (int t = 0; t < FILL_SPAN; t++)
        for (int n = 0; n < FILL_SPAN; n++)
          send_request(fvd_pkg::MODE_CORNER, ref_form(p, FILL_SPAN), ref_form(t, FILL_SPAN),
                       ref_form(n, FILL_SPAN));
    send_request(fvd_pkg::MODE_CORNER, -1, -1, -1);
    send_request(fvd_pkg::MODE_CORNER, 0, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, 7, 5, 3);
    send_request(fvd_pkg::MODE_POS, 0, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, FILL_SPAN, 0, 0);
    send_request(fvd_pkg::MODE_CORNER, -1, 5, -2);
    send_request(fvd_pkg::MODE_CORNER, FILL_SPAN + 1, 0, 0);
    wait_results_drained();
  endtask

  // Mostly valid corners among declarations and ignored modes, with noise and rare clears
  task automatic test_random_mix();
    int unsigned                sent;
    int unsigned                burst_left;
    int unsigned                w;
    int unsigned                rsvd_pick;
    logic [fvd_pkg::MODE_W-1:0] rsvd;
    sent       = 0;
    burst_left = 0;
    send_request(fvd_pkg::MODE_CLEAR, 0, 0, 0);
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        if ($urandom_range(3, 0) != 0) hold_off($urandom_range(12, 1));
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      if (sent == RANDOM_ITEMS / 2) wait_results_drained();
      w = $urandom_range(999, 0);
      if (w < 330 || w >= 350) sent++;
      if (w < 150) begin
        send_request(fvd_pkg::MODE_POS, $urandom, $urandom, $urandom);
      end else if (w < 240) begin
        send_request(fvd_pkg::MODE_TEX, $urandom, $urandom, $urandom);
      end else if (w < 330) begin
        send_request(fvd_pkg::MODE_NRM, $urandom, $urandom, $urandom);
      end else if (w < 350) begin
        rsvd_pick = $urandom_range(MODE_RSVD_LAST, MODE_RSVD_FIRST);
        rsvd      = rsvd_pick[fvd_pkg::MODE_W-1:0];
        send_request(rsvd, $urandom, $urandom, $urandom);
      end else if (w < 355) begin
        send_request(fvd_pkg::MODE_CLEAR, $urandom, $urandom, $urandom);
      end else if (w < 430) begin
        send_request(fvd_pkg::MODE_CORNER, noise_ref(pos_count), noise_ref(tex_count),
                     noise_ref(nrm_count));
      end else begin
        // tex and nrm are often omitted in real meshes
        send_request(fvd_pkg::MODE_CORNER, pick_ref(pos_count),
                     ($urandom_range(9, 0) < 3) ? 0 : pick_ref(tex_count),
                     ($urandom_range(9, 0) < 3) ? 0 : pick_ref(nrm_count));
      end
    end
    wait_results_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    mode_i       = fvd_pkg::MODE_POS;
    pos_ref_i    = '0;
    tex_ref_i    = '0;
    nrm_ref_i    = '0;
    pos_count    = 1;
    tex_count    = 1;
    nrm_count    = 1;
    stored_total = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_resolve_directed();
    test_clear_restart();
    test_dense_fill();
    test_random_mix();

    // Let a trailing clear sweep finish before the final verdict
    while (busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && expected_corners.size() == 0) begin
      $display("face_vertex_dedup_table verification clean");
    end else begin
      $display("face_vertex_dedup_table verification failed");
    end
    $finish;
  end

endmodule
